>>> rtl/isort_pkg.sv
`timescale 1ns / 1ps

package isort_pkg;

  // Capacity of the sorting chain, in cells.
  localparam int DEPTH = 64;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast from the control logic to every cell in the chain.
  typedef struct packed {
    logic   insert;     // place new_value into the ordered row
    logic   pop;        // shift the row one place toward cell 0
    value_t new_value;
  } cell_ctrl_t;

endpackage

>>> rtl/isort_ifs.sv
`timescale 1ns / 1ps

interface isort_in_if;
  logic                valid;
  logic                ready;
  isort_pkg::value_t   value;
  logic                set_end;

  modport source (output valid, output value, output set_end, input ready);
  modport sink (input valid, input value, input set_end, output ready);
endinterface

interface isort_out_if;
  logic                valid;
  logic                ready;
  isort_pkg::value_t   sorted_value;
  logic                is_last;
  logic                overflowed;

  modport source (output valid, output sorted_value, output is_last, output overflowed,
                  input ready);
  modport sink (input valid, input sorted_value, input is_last, input overflowed,
                output ready);
endinterface

>>> rtl/insertion_sorter_top.sv
`timescale 1ns / 1ps
// Insertion sorter: one request accepted per cycle while a set is being collected.
// N values give N results (DEPTH at most), one per cycle at full output rate, starting
// the cycle after the end-marked request; input is held off until the last result goes.
// Throughput is set by the chain of DEPTH compare-and-shift cells: one insert per cycle.
// Synchronous active-low reset empties every cell and clears the overflow flag.

module insertion_sorter_top (
  input logic clk,
  input logic rst_n,
  isort_in_if.sink    in_ch,
  isort_out_if.source out_ch
);

  isort_pkg::cell_ctrl_t ctrl;
  isort_pkg::value_t     cell_value [isort_pkg::DEPTH];
  logic                  cell_valid [isort_pkg::DEPTH];
  logic                  cell_le    [isort_pkg::DEPTH];

  logic draining_r, draining_nxt;
  logic ovf_r, ovf_nxt;
  logic in_accept;
  logic chain_full;
  logic pop_last;

  // Hold off new requests while a sorted set is being emitted.
  assign in_ch.ready = !draining_r;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // The far end of the chain is occupied: drop any further value of this set.
  assign chain_full = cell_valid[isort_pkg::DEPTH-1];

  assign ctrl.insert    = in_accept && !chain_full;
  assign ctrl.pop       = draining_r && out_ch.ready;
  assign ctrl.new_value = in_ch.value;

  // Results come straight from cell 0; the row advances toward it on each pop.
  assign out_ch.valid        = draining_r && cell_valid[0];
  assign out_ch.sorted_value = cell_value[0];
  assign out_ch.is_last      = !cell_valid[1];
  assign out_ch.overflowed   = ovf_r;

  assign pop_last = out_ch.valid && out_ch.ready && out_ch.is_last;

  always_comb begin
    draining_nxt = draining_r;
    ovf_nxt      = ovf_r;
    if (in_accept && chain_full) begin
      ovf_nxt = 1'b1;
    end
    if (in_accept && in_ch.set_end) begin
      draining_nxt = 1'b1;
    end
    // Last result of the set taken: the chain is empty again, clear for the next set.
    if (pop_last) begin
      draining_nxt = 1'b0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Chain of cells, kept in ascending order from cell 0 upward. Cell 0 sees an
  // always-occupied "left" that always holds its place, so a smallest value lands there.
  for (genvar i = 0; i < isort_pkg::DEPTH; i++) begin : g_cell
    isort_pkg::value_t lv;
    logic              lvld;
    logic              lle;
    isort_pkg::value_t rv;
    logic              rvld;

    if (i == 0) begin : g_head
      assign lv   = in_ch.value;
      assign lvld = 1'b1;
      assign lle  = 1'b1;
    end else begin : g_mid
      assign lv   = cell_value[i-1];
      assign lvld = cell_valid[i-1];
      assign lle  = cell_le[i-1];
    end

    if (i == isort_pkg::DEPTH - 1) begin : g_tail
      assign rv   = cell_value[i];
      assign rvld = 1'b0;
    end else begin : g_body
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_value  (lv),
      .left_valid  (lvld),
      .left_le     (lle),
      .right_value (rv),
      .right_valid (rvld),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .le          (cell_le[i])
    );
  end

endmodule

>>> rtl/isort_cell.sv
`timescale 1ns / 1ps

module isort_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isort_pkg::cell_ctrl_t ctrl,
  input  isort_pkg::value_t     left_value,
  input  logic                  left_valid,
  input  logic                  left_le,
  input  isort_pkg::value_t     right_value,
  input  logic                  right_valid,
  output isort_pkg::value_t     value,
  output logic                  valid,
  output logic                  le
);

  isort_pkg::value_t value_r, value_nxt;
  logic              valid_r, valid_nxt;

  // Stored entry is at or below the new value: it stays ahead of it.
  assign le = valid_r && (value_r <= ctrl.new_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.pop) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.insert) begin
      valid_nxt = valid_r | left_valid;
      if (!le) begin
        // Insertion point is here when the left neighbor stays put; else shift right.
        value_nxt = left_le ? ctrl.new_value : left_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule
